// ----- src/b2da_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int unsigned DefValueWidth = 64;
  localparam int unsigned CntW          = 5;
  localparam int unsigned CapW          = 8;
  localparam int unsigned InValW        = 64;
  localparam logic [7:0]  AsciiZero     = 8'h30;
  localparam logic [7:0]  AsciiNine     = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_EMIT,
    ST_ERR
  } state_e;

endpackage

// ----- src/binary_to_decimal_ascii.sv -----
// Binary to decimal ASCII converter: serial double dabble, digit-serial emit.
// Conversion: the BCD register shifts in one bit per cycle with add-3 correction, then leading
// zero digits are stripped one at a time, then each digit is registered as the sink frees it.
// A new value is accepted only in idle, once the last digit or the error item of the previous
// value has been registered for output.
// Reset: rst_ni asynchronous active low; returns to idle with no output pending.
module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = b2da_pkg::DefValueWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // [63:0] binary_value, [71:64] capacity
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [7:0] digit_char, [12:8] num_digits, [15:13] zero
  output logic        m_axis_tlast_o,  // is_last
  output logic        m_axis_tuser_o   // overflow_error
);
  import b2da_pkg::*;

  localparam int unsigned NDig  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BcdW  = 4 * NDig;
  localparam int unsigned BitW  = $clog2(VALUE_WIDTH);

  state_e               state_q, state_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [BcdW-1:0]      bcd_q, bcd_d, adj;
  logic [BitW-1:0]      bit_q, bit_d;
  logic [CapW-1:0]      cap_q, cap_d;
  logic [CntW-1:0]      rem_q, rem_d, num_q, num_d;
  logic                 mvalid_q, mvalid_d;
  logic [7:0]           char_q, char_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 last_q, last_d, err_q, err_d;
  logic                 s_fire, out_free, too_small;
  logic [3:0]           top;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !mvalid_q || m_axis_tready_i;
  assign top             = bcd_q[BcdW-1 -: 4];
  assign too_small       = (cap_q == '0) || (cap_q <= {{(CapW-CntW){1'b0}}, rem_q});

  always_comb begin
    for (int i = 0; i < NDig; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d  = state_q;
    val_d    = val_q;
    bcd_d    = bcd_q;
    bit_d    = bit_q;
    cap_d    = cap_q;
    rem_d    = rem_q;
    num_d    = num_q;
    mvalid_d = mvalid_q && !m_axis_tready_i;
    char_d   = char_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    err_d    = err_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          val_d   = s_axis_tdata_i[VALUE_WIDTH-1:0];
          cap_d   = s_axis_tdata_i[InValW +: CapW];
          bcd_d   = '0;
          bit_d   = BitW'(VALUE_WIDTH - 1);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = {adj[BcdW-2:0], val_q[VALUE_WIDTH-1]};
        val_d = val_q << 1;
        bit_d = bit_q - 1'b1;
        rem_d = CntW'(NDig);
        if (bit_q == '0) begin
          state_d = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (rem_q > CntW'(1) && top == 4'd0) begin
          bcd_d = bcd_q << 4;
          rem_d = rem_q - 1'b1;
        end else begin
          num_d   = rem_q;
          state_d = too_small ? ST_ERR : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          char_d   = AsciiZero + {4'd0, top};
          last_d   = (rem_q == CntW'(1));
          cnt_d    = (rem_q == CntW'(1)) ? num_q : '0;
          err_d    = 1'b0;
          bcd_d    = bcd_q << 4;
          rem_d    = rem_q - 1'b1;
          if (rem_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          char_d   = '0;
          last_d   = 1'b1;
          cnt_d    = '0;
          err_d    = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    bcd_q  <= bcd_d;
    bit_q  <= bit_d;
    cap_q  <= cap_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    char_q <= char_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {3'd0, cnt_q, char_q};
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = err_q;

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && char_q == '0 && cnt_q == '0)
    else $error("error item not marked last or not cleared");
  a_count_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> cnt_q == '0)
    else $error("digit count on non-final digit");
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> char_q >= AsciiZero && char_q <= AsciiNine)
    else $error("digit out of range");
  a_emit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> rem_q != '0 && rem_q <= num_q)
    else $error("digit counter out of range while emitting");
  a_final_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o && !m_axis_tuser_o |-> cnt_q != '0)
    else $error("final digit without count");
`endif

endmodule

// ----- tb/testbench.sv -----
// Testbench for binary_to_decimal_ascii: directed and random values checked against a predictor.
`timescale 1ns / 100ps

module testbench;
  import b2da_pkg::*;

  localparam int unsigned RandItems  = 357;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned MaxDigits  = 20;
  localparam int unsigned IdlePct    = 28;

  typedef struct {
    logic [7:0]      ch;
    logic [CntW-1:0] cnt;
    logic            is_last;
    logic            ovf;
  } dec_char_t;

  typedef struct {
    logic [InValW-1:0] val;
    logic [CapW-1:0]   cap;
    bit                typed;
    bit                ovf;
    string             txt;
  } dir_row_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  dec_char_t pending_digits[$];
  dir_row_t  dir_rows[$];
  int        bad_digits   = 0;
  int        quiet_cycles = 0;
  int        hold_reqs    = 0;
  int        hold_seen    = 0;
  bit        calm         = 1'b0;

  always #5 clk_i = ~clk_i;

  binary_to_decimal_ascii u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  function automatic int dec_len(input logic [InValW-1:0] v);
    int n;
    n = 1;
    while (v >= 10) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

  task automatic push_char(input logic [7:0] ch, input bit is_last, input bit ovf, input int cnt);
    dec_char_t item;
    item.ch      = ch;
    item.is_last = is_last;
    item.ovf     = ovf;
    item.cnt     = CntW'(cnt);
    pending_digits.push_back(item);
  endtask

  task automatic predict_digits(input logic [InValW-1:0] v, input logic [CapW-1:0] cap);
    int                digs[MaxDigits];
    int                n;
    logic [InValW-1:0] r;
    r = v;
    n = 0;
    do begin
      digs[n] = int'(r % 10);
      r = r / 10;
      n++;
    end while (r != 0);
    if (int'(cap) < n + 1) begin
      push_char(8'h00, 1'b1, 1'b1, 0);
    end else begin
      for (int i = 0; i < n; i++) begin
        push_char(AsciiZero + 8'(digs[n-1-i]), i == n - 1, 1'b0, (i == n - 1) ? n : 0);
      end
    end
  endtask

  task automatic add_row(input logic [InValW-1:0] v, input logic [CapW-1:0] cap,
                         input bit typed, input bit ovf, input string txt);
    dir_row_t row;
    row.val   = v;
    row.cap   = cap;
    row.typed = typed;
    row.ovf   = ovf;
    row.txt   = txt;
    dir_rows.push_back(row);
  endtask

  task automatic send_value(input logic [InValW-1:0] v, input logic [CapW-1:0] cap,
                            input bit typed, input bit ovf, input string txt);
    int len;
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {cap, v};
    do @(posedge clk_i); while (!s_tready);
    len = txt.len();
    if (!typed) begin
      predict_digits(v, cap);
    end else if (ovf) begin
      push_char(8'h00, 1'b1, 1'b1, 0);
    end else begin
      for (int i = 0; i < len; i++) begin
        push_char(txt[i], i == len - 1, 1'b0, (i == len - 1) ? len : 0);
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    dec_char_t want;
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Some tests failed");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        if (pending_digits.size() == 0) begin
          bad_digits++;
          if (bad_digits <= 10) begin
            $display("unexpected transfer: tdata=%h tlast=%b tuser=%b", m_tdata, m_tlast, m_tuser);
          end
        end else begin
          want = pending_digits.pop_front();
          if (m_tdata[7:0] !== want.ch || m_tdata[12:8] !== want.cnt || m_tdata[15:13] !== 3'b000 ||
              m_tlast !== want.is_last || m_tuser !== want.ovf) begin
            bad_digits++;
            if (bad_digits <= 10) begin
              $display("mismatch: exp char %h cnt %0d last %b err %b, got tdata %h last %b err %b",
                       want.ch, want.cnt, want.is_last, want.ovf, m_tdata, m_tlast, m_tuser);
            end
          end
        end
      end
    end
  end

  initial begin
    logic [InValW-1:0] v;
    logic [CapW-1:0]   cap;
    int                n;
    int                pick;

    add_row(64'd0, 8'd0, 1'b1, 1'b1, "");
    add_row(64'd0, 8'd1, 1'b1, 1'b1, "");
    add_row(64'd0, 8'd2, 1'b1, 1'b0, "0");
    add_row('1, 8'd0, 1'b1, 1'b1, "");
    add_row('1, 8'd20, 1'b1, 1'b1, "");
    add_row('1, 8'd21, 1'b1, 1'b0, "18446744073709551615");
    add_row('1, 8'd255, 1'b1, 1'b0, "18446744073709551615");
    add_row(64'd9, 8'd2, 1'b1, 1'b0, "9");
    add_row(64'd10, 8'd2, 1'b1, 1'b1, "");
    add_row(64'd10, 8'd3, 1'b1, 1'b0, "10");
    add_row(64'd9999999999999999999, 8'd20, 1'b1, 1'b0, "9999999999999999999");
    add_row(64'd9999999999999999999, 8'd19, 1'b1, 1'b1, "");
    add_row(64'd10000000000000000000, 8'd21, 1'b1, 1'b0, "10000000000000000000");
    add_row(64'd10000000000000000000, 8'd20, 1'b1, 1'b1, "");
    add_row(64'd1, 8'h80, 1'b0, 1'b0, "");
    add_row(64'd123456789, 8'd10, 1'b0, 1'b0, "");
    add_row(64'd123456789, 8'd9, 1'b0, 1'b0, "");
    add_row(64'h8000_0000_0000_0000, 8'd21, 1'b0, 1'b0, "");
    add_row(64'h5555_5555_5555_5555, 8'haa, 1'b0, 1'b0, "");
    add_row(64'haaaa_aaaa_aaaa_aaaa, 8'h55, 1'b0, 1'b0, "");
    add_row(64'd99, 8'd3, 1'b0, 1'b0, "");
    add_row(64'd100, 8'd3, 1'b0, 1'b0, "");
    add_row(64'd100, 8'd4, 1'b0, 1'b0, "");

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_value(dir_rows[i].val, dir_rows[i].cap, dir_rows[i].typed, dir_rows[i].ovf,
                 dir_rows[i].txt);
    end

    for (int i = 0; i < RandItems; i++) begin
      calm = (i >= 120 && i < 200);
      if (i == 150) hold_reqs++;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        v = InValW'($urandom_range(0, 20));
      end else if (pick < 12) begin
        v = '1;
      end else begin
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
      end
      n = dec_len(v);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        cap = CapW'(n + 1 + $urandom_range(0, 3));
      end else if (pick < 77) begin
        cap = CapW'(n);
      end else if (pick < 82) begin
        cap = '0;
      end else if (pick < 90) begin
        cap = CapW'($urandom_range(21, 255));
      end else begin
        cap = CapW'($urandom_range(0, 255));
      end
      send_value(v, cap, 1'b0, 1'b0, "");
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (bad_digits == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
